### rtl/core/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Types and constants shared by the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned LimitW  = 16;
	localparam int unsigned CountW  = 8;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 16;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_DOWN      = 3'd1,
		EV_SUSTAINED = 3'd2,
		EV_OVERPET   = 3'd3,
		EV_SHORT     = 3'd4
	} event_code_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TOUCH_THRESHOLD     = 3'd0,
		REG_DEBOUNCE_NEEDED     = 3'd1,
		REG_SHORT_LIMIT_MS      = 3'd2,
		REG_OVERPET_AFTER_MS    = 3'd3,
		REG_OVERPET_REPEAT_MS   = 3'd4,
		REG_SUSTAINED_REPEAT_MS = 3'd5
	} cfg_reg_t;

	localparam logic [SampleW-1:0] RST_TOUCH_THRESHOLD     = 16'd35;
	localparam logic [CountW-1:0]  RST_DEBOUNCE_NEEDED     = 8'd2;
	localparam logic [LimitW-1:0]  RST_SHORT_LIMIT_MS      = 16'd1200;
	localparam logic [LimitW-1:0]  RST_OVERPET_AFTER_MS    = 16'd5500;
	localparam logic [LimitW-1:0]  RST_OVERPET_REPEAT_MS   = 16'd1800;
	localparam logic [LimitW-1:0]  RST_SUSTAINED_REPEAT_MS = 16'd2200;

	typedef struct packed {
		logic [SampleW-1:0] touch_threshold;
		logic [CountW-1:0]  debounce_needed;
		logic [LimitW-1:0]  short_limit_ms;
		logic [LimitW-1:0]  overpet_after_ms;
		logic [LimitW-1:0]  overpet_repeat_ms;
		logic [LimitW-1:0]  sustained_repeat_ms;
	} cfg_t;

	typedef struct packed {
		logic [CountW-1:0] debounce_count;
		logic              hold_active;
		logic [TimeW-1:0]  hold_start_time;
		logic [TimeW-1:0]  last_event_time;
	} state_t;

endpackage

### rtl/core/tgc_if.sv
// ----------------------------------------------------------------------------
// tgc_if
// Valid/ready channels of the touch gesture classifier.
// ----------------------------------------------------------------------------
interface tgc_sample_if;
	logic                         valid;
	logic                         ready;
	logic [tgc_pkg::SampleW-1:0]  touch_sample;
	logic [tgc_pkg::TimeW-1:0]    time_ms;
	modport source (output valid, touch_sample, time_ms, input ready);
	modport sink   (input valid, touch_sample, time_ms, output ready);
endinterface

interface tgc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic       holding;
	modport source (output valid, event_code, holding, input ready);
	modport sink   (input valid, event_code, holding, output ready);
endinterface

interface tgc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tgc_pkg::CfgIdxW-1:0]  index;
	logic [tgc_pkg::CfgDatW-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/tgc_step.sv
// ----------------------------------------------------------------------------
// tgc_step
// Next-state and event logic for one touch sample.
// ----------------------------------------------------------------------------
module tgc_step (
	input  tgc_pkg::cfg_t                 cfg,
	input  tgc_pkg::state_t               cur,
	input  logic [tgc_pkg::SampleW-1:0]   touch_sample,
	input  logic [tgc_pkg::TimeW-1:0]     time_ms,
	output tgc_pkg::state_t               nxt,
	output tgc_pkg::event_code_t          event_code
);

	logic                        touched;
	logic [tgc_pkg::CountW-1:0]  cnt_inc;
	logic [tgc_pkg::TimeW-1:0]   dur;
	logic [tgc_pkg::TimeW-1:0]   since_ev;

	assign touched  = (touch_sample != '0) && (touch_sample < cfg.touch_threshold);
	assign cnt_inc  = (&cur.debounce_count) ? cur.debounce_count
	                                        : cur.debounce_count + 1'b1;
	assign dur      = time_ms - cur.hold_start_time;
	assign since_ev = time_ms - cur.last_event_time;

	always_comb begin
		nxt        = cur;
		event_code = tgc_pkg::EV_NONE;
		if (touched) begin
			nxt.debounce_count = cnt_inc;
			if (cnt_inc >= cfg.debounce_needed) begin
				if (!cur.hold_active) begin
					// the hold starts at this word's time; only the touch-down event fires on it
					nxt.hold_active     = 1'b1;
					nxt.hold_start_time = time_ms;
					nxt.last_event_time = time_ms;
					event_code          = tgc_pkg::EV_DOWN;
				end else if (dur > {16'd0, cfg.overpet_after_ms}) begin
					if (since_ev > {16'd0, cfg.overpet_repeat_ms}) begin
						nxt.last_event_time = time_ms;
						event_code          = tgc_pkg::EV_OVERPET;
					end
				end else if (dur > {16'd0, cfg.short_limit_ms}) begin
					if (since_ev > {16'd0, cfg.sustained_repeat_ms}) begin
						nxt.last_event_time = time_ms;
						event_code          = tgc_pkg::EV_SUSTAINED;
					end
				end
			end
		end else begin
			nxt.debounce_count = '0;
			if (cur.hold_active) begin
				nxt.hold_active = 1'b0;
				if (dur < {16'd0, cfg.short_limit_ms}) begin
					event_code = tgc_pkg::EV_SHORT;
				end
			end
		end
	end

endmodule

### rtl/core/touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Turns time-stamped capacitive touch samples into gesture events.
// ----------------------------------------------------------------------------
// Channels: samples (touch_sample, time_ms) in, events (event_code, holding)
// out, cfg writes one of six limit registers by index; writes to an index
// above five are dropped. cfg is always ready and must be written only
// while idle; the block does not enforce this. Every accepted sample gives
// exactly one event word, in order. An accepted sample sits in the input
// register, then moves into the result register once that is empty or its
// word is taken. Throughput: one sample per cycle while each word is taken;
// the classification is a single pass of subtracts and compares on the hold
// state, which is updated as the word moves into the result register.
// When the receiver stalls, the result register holds its word and the input
// register takes one more sample; samples.ready then drops until the result
// is taken.
// Reset: clears the debounce count and hold state, restores the register
// defaults (threshold 35, debounce 2, short 1200, over-pet 5500, over-pet
// repeat 1800, sustained repeat 2200) and empties both registers.
// ----------------------------------------------------------------------------
module touch_gesture_classifier (
	input  logic         clk,
	input  logic         arst_n,
	tgc_sample_if.sink   samples,
	tgc_event_if.source  events,
	tgc_cfg_if.sink      cfg
);

	tgc_pkg::cfg_t                 cfg_q;
	tgc_pkg::state_t               state_q;
	tgc_pkg::state_t               state_nxt;
	tgc_pkg::event_code_t          ev_nxt;

	logic                          valid_s1;
	logic [tgc_pkg::SampleW-1:0]   sample_s1;
	logic [tgc_pkg::TimeW-1:0]     time_s1;

	logic                          ev_valid_q;
	logic [2:0]                    ev_code_q;
	logic                          holding_q;

	logic                          adv;
	logic                          in_acc;

	assign adv           = valid_s1 && (!ev_valid_q || events.ready);
	assign samples.ready = !valid_s1 || adv;
	assign in_acc        = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_threshold     <= tgc_pkg::RST_TOUCH_THRESHOLD;
			cfg_q.debounce_needed     <= tgc_pkg::RST_DEBOUNCE_NEEDED;
			cfg_q.short_limit_ms      <= tgc_pkg::RST_SHORT_LIMIT_MS;
			cfg_q.overpet_after_ms    <= tgc_pkg::RST_OVERPET_AFTER_MS;
			cfg_q.overpet_repeat_ms   <= tgc_pkg::RST_OVERPET_REPEAT_MS;
			cfg_q.sustained_repeat_ms <= tgc_pkg::RST_SUSTAINED_REPEAT_MS;
		end else if (cfg.valid) begin
			unique case (tgc_pkg::cfg_reg_t'(cfg.index))
				tgc_pkg::REG_TOUCH_THRESHOLD:     cfg_q.touch_threshold     <= cfg.data;
				tgc_pkg::REG_DEBOUNCE_NEEDED:     cfg_q.debounce_needed     <= cfg.data[7:0];
				tgc_pkg::REG_SHORT_LIMIT_MS:      cfg_q.short_limit_ms      <= cfg.data;
				tgc_pkg::REG_OVERPET_AFTER_MS:    cfg_q.overpet_after_ms    <= cfg.data;
				tgc_pkg::REG_OVERPET_REPEAT_MS:   cfg_q.overpet_repeat_ms   <= cfg.data;
				tgc_pkg::REG_SUSTAINED_REPEAT_MS: cfg_q.sustained_repeat_ms <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= samples.touch_sample;
			time_s1   <= samples.time_ms;
		end
	end

	tgc_step u_step (
		.cfg          (cfg_q),
		.cur          (state_q),
		.touch_sample (sample_s1),
		.time_ms      (time_s1),
		.nxt          (state_nxt),
		.event_code   (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (adv) begin
			ev_valid_q <= 1'b1;
		end else if (events.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_code_q <= ev_nxt;
			holding_q <= state_nxt.hold_active;
		end
	end

	assign events.valid      = ev_valid_q;
	assign events.event_code = ev_code_q;
	assign events.holding    = holding_q;

endmodule

### rtl/core/tgc_checker.sv
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks on the event channel of the touch gesture classifier.
// ----------------------------------------------------------------------------
module tgc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       ev_valid,
	input logic       ev_ready,
	input logic [2:0] ev_code,
	input logic       ev_holding
);

	logic ev_acc;
	assign ev_acc = ev_valid && ev_ready;

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid)
		else $error("event word dropped while stalled");

	// touch-down and repeated events only come with a hold in progress
	a_down_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ev_acc && (ev_code == tgc_pkg::EV_DOWN || ev_code == tgc_pkg::EV_SUSTAINED
		           || ev_code == tgc_pkg::EV_OVERPET) |-> ev_holding)
		else $error("hold event without holding");

	// a short tap ends the hold
	a_short_release: assert property (@(posedge clk) disable iff (!arst_n)
		ev_acc && ev_code == tgc_pkg::EV_SHORT |-> !ev_holding)
		else $error("short tap while still holding");

	// no event code beyond short tap
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ev_code <= tgc_pkg::EV_SHORT)
		else $error("event code out of range");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.ev_valid   (events.valid),
	.ev_ready   (events.ready),
	.ev_code    (events.event_code),
	.ev_holding (events.holding)
);
